[hw/rtl/ubrp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ubrp_pkg
// Shared constants, command codes and control/status types for the bulk IN
// ring packetizer.
// ----------------------------------------------------------------------------
package ubrp_pkg;

    localparam int RING_DEPTH = 2048;
    localparam int MAX_PACKET = 64;

    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam int IDX_W   = RING_AW + 1;
    localparam int LEN_W   = $clog2(MAX_PACKET + 1);
    localparam int DATA_W  = 8;
    localparam int KIND_W  = 2;
    localparam int PS_W    = 7;
    localparam int PS_RESET = 64;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_PACKET_SIZE = REG_IDX_W'(0);

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHUNK,
        ST_READ,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic wr_byte;
        logic tick;
        logic stop;
        logic load_chunk;
        logic rd_issue;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic sending;
        logic tick_hit;
        logic span_zero;
        logic last_byte;
    } status_t;

endpackage

`default_nettype wire

[hw/rtl/ubrp_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ubrp_ctrl
// Controller: takes input items, sequences chunk setup, memory reads and the
// hand-off of each packet byte.
// ----------------------------------------------------------------------------
module ubrp_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    input  wire logic [ubrp_pkg::KIND_W-1:0] s_kind,
    output logic                             s_ready,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    input  wire ubrp_pkg::status_t           status,
    output ubrp_pkg::cmd_t                   cmd
);
    import ubrp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_kind)
                        KIND_WRITE: begin
                            cmd.wr_byte = 1'b1;
                        end
                        KIND_TICK: begin
                            cmd.tick = 1'b1;
                            if (status.tick_hit) begin
                                state_next = ST_CHUNK;
                            end
                        end
                        KIND_DONE: begin
                            if (status.sending) begin
                                if (status.span_zero) begin
                                    cmd.stop = 1'b1;
                                end else begin
                                    state_next = ST_CHUNK;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CHUNK: begin
                cmd.load_chunk = 1'b1;
                state_next     = ST_READ;
            end
            ST_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.advance = 1'b1;
                    state_next  = status.last_byte ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/ubrp_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ubrp_datapath
// Ring memory, write/read indices, span tracking and the packet byte
// counter.
// ----------------------------------------------------------------------------
module ubrp_datapath (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire ubrp_pkg::cmd_t              cmd,
    input  wire logic [ubrp_pkg::DATA_W-1:0] data_byte,
    input  wire logic [ubrp_pkg::PS_W-1:0]   packet_size,
    output ubrp_pkg::status_t                status,
    output logic [ubrp_pkg::DATA_W-1:0]      tx_byte,
    output logic [ubrp_pkg::LEN_W-1:0]       packet_length
);
    import ubrp_pkg::*;

    logic [DATA_W-1:0]  mem [RING_DEPTH];
    logic [DATA_W-1:0]  rdata_reg;

    logic [RING_AW-1:0] wr_idx_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [IDX_W-1:0]   span_reg;
    logic               sending_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   cnt_reg;

    logic [IDX_W-1:0]   rd_wrapped;
    logic [IDX_W-1:0]   wr_ext;
    logic [IDX_W-1:0]   span_new;
    logic [LEN_W-1:0]   eff_size;
    logic [LEN_W-1:0]   chunk_len;

    assign wr_ext     = {1'b0, wr_idx_reg};
    assign rd_wrapped = (rd_idx_reg >= IDX_W'(RING_DEPTH)) ? '0 : rd_idx_reg;
    assign span_new   = (rd_wrapped > wr_ext) ? IDX_W'(RING_DEPTH) - rd_wrapped
                                              : wr_ext - rd_wrapped;

    // A size of zero acts as one byte; oversized values clamp to the maximum.
    always_comb begin
        if (packet_size == '0) begin
            eff_size = LEN_W'(1);
        end else if (int'(packet_size) > MAX_PACKET) begin
            eff_size = LEN_W'(MAX_PACKET);
        end else begin
            eff_size = LEN_W'(packet_size);
        end
    end

    assign chunk_len = (span_reg > IDX_W'(eff_size)) ? eff_size : LEN_W'(span_reg);

    always_ff @(posedge aclk) begin
        if (cmd.wr_byte) begin
            mem[wr_idx_reg] <= data_byte;
        end
        if (cmd.rd_issue) begin
            rdata_reg <= mem[rd_idx_reg[RING_AW-1:0]];
        end
        if (cmd.load_chunk) begin
            len_reg <= chunk_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg  <= '0;
            rd_idx_reg  <= '0;
            span_reg    <= '0;
            sending_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            if (cmd.wr_byte) begin
                wr_idx_reg <= (wr_idx_reg == RING_AW'(RING_DEPTH - 1)) ? '0
                                                                       : wr_idx_reg + 1'b1;
            end
            if (cmd.tick && !sending_reg) begin
                rd_idx_reg <= rd_wrapped;
                if (rd_wrapped != wr_ext) begin
                    span_reg    <= span_new;
                    sending_reg <= 1'b1;
                end
            end
            if (cmd.stop) begin
                sending_reg <= 1'b0;
            end
            if (cmd.load_chunk) begin
                cnt_reg <= '0;
            end
            // Each delivered byte moves the read side forward by one.
            if (cmd.advance) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
                span_reg   <= span_reg - 1'b1;
                cnt_reg    <= cnt_reg + 1'b1;
            end
        end
    end

    assign status.sending   = sending_reg;
    assign status.tick_hit  = !sending_reg && (rd_wrapped != wr_ext);
    assign status.span_zero = (span_reg == '0);
    assign status.last_byte = (cnt_reg == LEN_W'(len_reg - 1'b1));

    assign tx_byte       = rdata_reg;
    assign packet_length = len_reg;

endmodule

`default_nettype wire

[hw/rtl/usb_bulk_in_ring_packetizer_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// usb_bulk_in_ring_packetizer_core
// Byte ring buffer feeding a bulk IN endpoint one packet at a time.
// ----------------------------------------------------------------------------
// A write item or an ignored item is taken in the idle state; a tick or
// IN-complete that starts a packet is accepted in idle, the chunk is sized in
// the chunk state, then each byte passes a memory read state and an output
// state, and output stalls hold the output state. The controller goes through
// a read state and an output state for every byte.
// Reset clears the indices, the span and the busy flag and sets packet_size
// to 64; the ring contents are not cleared.
module usb_bulk_in_ring_packetizer_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ubrp_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [ubrp_pkg::PDATA_W-1:0]   pwdata,
    output logic [ubrp_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [ubrp_pkg::KIND_W-1:0]    s_kind,
    input  wire logic [ubrp_pkg::DATA_W-1:0]    s_data_byte,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [ubrp_pkg::DATA_W-1:0]         m_tx_byte,
    output logic [ubrp_pkg::LEN_W-1:0]          m_packet_length,
    output logic                                m_last_of_packet
);
    import ubrp_pkg::*;

    logic [PS_W-1:0]      packet_size_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    cmd_t                 cmd;
    status_t              status;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == REG_PACKET_SIZE) ? PDATA_W'(packet_size_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            packet_size_reg <= PS_W'(PS_RESET);
        end else if (psel && penable && pwrite && pready
                     && (reg_idx == REG_PACKET_SIZE)) begin
            packet_size_reg <= pwdata[PS_W-1:0];
        end
    end

    ubrp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ubrp_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .data_byte     (s_data_byte),
        .packet_size   (packet_size_reg),
        .status        (status),
        .tx_byte       (m_tx_byte),
        .packet_length (m_packet_length)
    );

    assign m_last_of_packet = status.last_byte;

    // Input and output sides never overlap while a packet is in flight.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while a packet byte is pending");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_of_packet) |=> s_ready)
        else $error("controller did not return to idle after the last byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_packet) |=> $stable(m_packet_length))
        else $error("packet length changed inside a packet");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_packet_length != '0))
        else $error("empty packet presented");

endmodule

`default_nettype wire
